### hdl/fbd_pkg.sv
// shared types and constants for the face box decoder with hard nms
// no dependencies
`default_nettype none

package fbd_pkg;

  localparam int FINE_ANCHORS   = 512;
  localparam int COARSE_ANCHORS = 384;
  localparam int TOTAL_ANCHORS  = FINE_ANCHORS + COARSE_ANCHORS;
  localparam int IDX_W          = 10;
  localparam int MAX_CAND_DEF   = 64;
  localparam int RESULT_LIMIT   = 64;
  localparam int EMIT_W         = 7;
  localparam int SIG_STEPS      = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DET     = 2'd2;

  localparam logic signed [15:0] SCORE_THR_RST = 16'sd104;
  localparam logic [7:0]         OVL_THR_RST   = 8'd128;
  localparam logic [6:0]         MAX_DET_RST   = 7'd64;

  localparam logic [15:0] SIG_HALF = 16'h8000;

  // multiplier operand widths of the shared unit
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [15:0]        conf;
  } cand_t;

  typedef enum logic [3:0] {
    S_IN,
    S_DIV,
    S_WRITE,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_OV_IW,
    S_OV_INTER,
    S_OV_AREA,
    S_OV_UNION,
    S_OV_THR,
    S_OV_CMP,
    S_ROUND_END,
    S_OUT,
    S_PROMOTE,
    S_AREA
  } fbd_state_e;

endpackage

`default_nettype wire

### hdl/fbd_if.sv
// channel interfaces of the face box decoder: anchors in, results out, config writes
// depends on fbd_pkg
`default_nettype none

interface fbd_anchor_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score_logit;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] size_w;
  logic signed [15:0] size_h;
  modport source (output valid, score_logit, offset_x, offset_y, size_w, size_h,
                  input ready);
  modport sink (input valid, score_logit, offset_x, offset_y, size_w, size_h,
                output ready);
endinterface

interface fbd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic [14:0]        box_width;
  logic [14:0]        box_height;
  logic [15:0]        confidence;
  logic               none_found;
  logic               frame_end;
  modport source (output valid, box_left, box_top, box_width, box_height, confidence,
                  none_found, frame_end, input ready);
  modport sink (input valid, box_left, box_top, box_width, box_height, confidence,
                none_found, frame_end, output ready);
endinterface

interface fbd_cfg_if;
  import fbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/face_box_decode_nms_core.sv
// face box decoder with hard nms, top level
// depends on fbd_pkg and the channel interfaces in fbd_if.sv
`default_nettype none

// Takes 896 anchors per frame (512 fine, then 384 coarse) and emits the surviving
// boxes of the frame by descending confidence after the last anchor. An anchor that
// is dropped is only accepted. An anchor that is stored passes through accept, 15
// steps of the bit-serial divider that forms the sigmoid, and the store write. After
// the last anchor, each nms round is one scan over the stored candidates through the
// single read port of the candidate store: read and evaluate for a skipped
// candidate or while no box is chosen, adding the width and intersection steps when
// boxes do not intersect, and area, union, threshold and compare when the iou test
// runs on the shared multiplier. Each round adds bookkeeping (scan start, end of
// scan, round end, promote, chosen box area) plus the output wait. Candidate marks
// are flip-flops cleared at the end of each frame, so no clearing pass is needed.
module face_box_decode_nms_core
  import fbd_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CAND_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbd_cfg_if.sink      cfg_i,
  fbd_anchor_if.sink   anchor_i,
  fbd_result_if.source result_o
);

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  fbd_state_e state_q, state_d;

  // configuration
  logic signed [15:0] score_thr_q;
  logic [7:0]         ovl_thr_q;
  logic [6:0]         max_det_q;

  // anchor position
  logic [IDX_W-1:0] anchor_idx_q;
  logic [2:0]       sub_q;
  logic [3:0]       cx_q, cy_q;

  // frame state
  logic [CW-1:0]             cand_cnt_q;
  logic [EMIT_W-1:0]         emit_cnt_q;
  logic [MAX_CANDIDATES-1:0] marks_q;

  // latched anchor
  logic               neg_q, last_q;
  logic signed [15:0] ox_q, oy_q, w_q, h_q;
  logic [14:0]        centre_x_q, centre_y_q;

  // divider
  logic [16:0] rem_q, den_q;
  logic [14:0] quo_q;
  logic [3:0]  step_q;

  // store and scan
  cand_t            mem_q [MAX_CANDIDATES];
  cand_t            rd_q;
  logic [CW-1:0]    scan_i_q;
  logic             have_best_q, have_next_q;
  logic [AW-1:0]    best_idx_q, next_idx_q;
  cand_t            best_q, next_q;
  logic [29:0]      area_best_q;
  logic signed [17:0] iw_q, ih_q;
  logic [29:0]      inter_q, uni_q;
  logic [MUL_P_W-1:0] prod_q;

  // output register
  cand_t out_q;
  logic  out_none_q, out_end_q;

  // ---------------------------------------------------------------- decode
  logic       anchor_acc, result_acc, cfg_acc;
  logic       is_fine, is_last, keep;
  logic [15:0] abs_logit;
  logic [14:0] centre_x, centre_y;
  logic [6:0]  limit;
  logic [EMIT_W-1:0] emit_next;

  assign anchor_acc = anchor_i.valid && anchor_i.ready;
  assign result_acc = result_o.valid && result_o.ready;
  assign cfg_acc    = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign is_fine = anchor_idx_q < IDX_W'(FINE_ANCHORS);
  assign is_last = anchor_idx_q == IDX_W'(TOTAL_ANCHORS - 1);

  assign keep = (anchor_i.score_logit > score_thr_q)
             && !anchor_i.size_w[15] && (anchor_i.size_w != '0)
             && !anchor_i.size_h[15] && (anchor_i.size_h != '0)
             && (cand_cnt_q < CW'(MAX_CANDIDATES));

  assign abs_logit = anchor_i.score_logit[15] ? 16'(-anchor_i.score_logit)
                                              : anchor_i.score_logit;

  // fine centre (2c+1)*1024, coarse centre (2c+1)*2048
  assign centre_x = is_fine ? {cx_q, 1'b1, 10'b0} : {cx_q[2:0], 1'b1, 11'b0};
  assign centre_y = is_fine ? {cy_q, 1'b1, 10'b0} : {cy_q[2:0], 1'b1, 11'b0};

  // detection limit clamped to 1..64
  always_comb begin
    if (max_det_q == '0) begin
      limit = 7'd1;
    end else if (max_det_q > 7'(RESULT_LIMIT)) begin
      limit = 7'(RESULT_LIMIT);
    end else begin
      limit = max_det_q;
    end
  end
  assign emit_next = emit_cnt_q + 1'b1;

  // box edges from the latched anchor: floor((2*(off + centre) - size + 2) / 4)
  logic signed [18:0] ex, ey;
  logic signed [16:0] rx, ry;
  logic signed [15:0] left_sat, top_sat;
  logic [15:0]        w_inc, h_inc;
  cand_t              new_cand;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign ex = ((19'(ox_q) + $signed({4'b0, centre_x_q})) <<< 1) - 19'(w_q) + 19'sd2;
  assign ey = ((19'(oy_q) + $signed({4'b0, centre_y_q})) <<< 1) - 19'(h_q) + 19'sd2;
  assign rx = ex[18:2];
  assign ry = ey[18:2];
  assign left_sat = sat16(rx);
  assign top_sat  = sat16(ry);
  assign w_inc = w_q + 16'd1;
  assign h_inc = h_q + 16'd1;

  always_comb begin
    new_cand.left   = left_sat;
    new_cand.top    = top_sat;
    new_cand.width  = w_inc[15:1];
    new_cand.height = h_inc[15:1];
    new_cand.conf   = neg_q ? SIG_HALF - {1'b0, quo_q} : SIG_HALF + {1'b0, quo_q};
  end

  // divider step, one quotient bit a cycle
  logic [17:0] rem2;
  logic        rem_ge;
  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den_q};

  // intersection of the chosen box with the candidate under test
  logic signed [16:0] a_r, b_r, ix2, ay2, by2, iy2;
  logic signed [15:0] ix1, iy1;
  assign ix1 = (best_q.left > rd_q.left) ? best_q.left : rd_q.left;
  assign iy1 = (best_q.top > rd_q.top) ? best_q.top : rd_q.top;
  assign a_r = 17'(best_q.left) + $signed({2'b0, best_q.width});
  assign b_r = 17'(rd_q.left) + $signed({2'b0, rd_q.width});
  assign ay2 = 17'(best_q.top) + $signed({2'b0, best_q.height});
  assign by2 = 17'(rd_q.top) + $signed({2'b0, rd_q.height});
  assign ix2 = (a_r < b_r) ? a_r : b_r;
  assign iy2 = (ay2 < by2) ? ay2 : by2;

  logic no_isect, overlap, cur_marked, cur_is_best;
  assign no_isect   = (iw_q <= 18'sd0) || (ih_q <= 18'sd0);
  assign overlap    = {inter_q, 8'b0} > prod_q[37:0];
  assign cur_marked = marks_q[scan_i_q[AW-1:0]];
  assign cur_is_best = have_best_q && (scan_i_q[AW-1:0] == best_idx_q);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IN: begin
        if (anchor_acc) begin
          if (keep) begin
            state_d = S_DIV;
          end else if (is_last) begin
            state_d = S_SCAN_INIT;
          end
        end
      end
      S_DIV: begin
        if (step_q == 4'(SIG_STEPS - 1)) state_d = S_WRITE;
      end
      S_WRITE:     state_d = last_q ? S_SCAN_INIT : S_IN;
      S_SCAN_INIT: state_d = S_SCAN_RD;
      S_SCAN_RD:   state_d = (scan_i_q == cand_cnt_q) ? S_ROUND_END : S_SCAN_EVAL;
      S_SCAN_EVAL: begin
        if (cur_marked || cur_is_best || !have_best_q) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_OV_IW;
        end
      end
      S_OV_IW:    state_d = S_OV_INTER;
      S_OV_INTER: state_d = no_isect ? S_SCAN_RD : S_OV_AREA;
      S_OV_AREA:  state_d = S_OV_UNION;
      S_OV_UNION: state_d = S_OV_THR;
      S_OV_THR:   state_d = S_OV_CMP;
      S_OV_CMP:   state_d = S_SCAN_RD;
      S_ROUND_END: begin
        if (have_best_q || !have_next_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_PROMOTE;
        end
      end
      S_OUT: begin
        if (result_acc) state_d = out_end_q ? S_IN : S_PROMOTE;
      end
      S_PROMOTE: state_d = (emit_next == limit) ? S_OUT : S_AREA;
      S_AREA:    state_d = S_SCAN_INIT;
      default:   state_d = S_IN;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  logic               cons_en, mark_en, scan_adv;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  always_comb begin
    cons_en  = 1'b0;
    mark_en  = 1'b0;
    scan_adv = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      S_SCAN_EVAL: begin
        if (!cur_marked) begin
          if (cur_is_best) begin
            mark_en = 1'b1;
          end else if (!have_best_q) begin
            cons_en = 1'b1;
          end
        end
        scan_adv = cur_marked || cur_is_best || !have_best_q;
      end
      S_OV_INTER: begin
        mul_a    = iw_q[15:0];
        mul_b    = MUL_B_W'(ih_q[15:0]);
        cons_en  = no_isect;
        scan_adv = no_isect;
      end
      S_OV_AREA: begin
        mul_a = MUL_A_W'(rd_q.width);
        mul_b = MUL_B_W'(rd_q.height);
      end
      S_OV_THR: begin
        mul_a = MUL_A_W'(ovl_thr_q);
        mul_b = uni_q;
      end
      S_OV_CMP: begin
        mark_en  = overlap;
        cons_en  = !overlap;
        scan_adv = 1'b1;
      end
      S_AREA: begin
        mul_a = MUL_A_W'(best_q.width);
        mul_b = MUL_B_W'(best_q.height);
      end
      default: begin
      end
    endcase
  end

  assign anchor_i.ready = (state_q == S_IN);
  assign result_o.valid = (state_q == S_OUT);
  assign result_o.box_left   = out_q.left;
  assign result_o.box_top    = out_q.top;
  assign result_o.box_width  = out_q.width;
  assign result_o.box_height = out_q.height;
  assign result_o.confidence = out_q.conf;
  assign result_o.none_found = out_none_q;
  assign result_o.frame_end  = out_end_q;

  logic frame_done;
  assign frame_done = result_acc && out_end_q;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IN;
      score_thr_q  <= SCORE_THR_RST;
      ovl_thr_q    <= OVL_THR_RST;
      max_det_q    <= MAX_DET_RST;
      anchor_idx_q <= '0;
      sub_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      cand_cnt_q   <= '0;
      emit_cnt_q   <= '0;
      marks_q      <= '0;
      step_q       <= '0;
      scan_i_q     <= '0;
      have_best_q  <= 1'b0;
      have_next_q  <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        case (cfg_i.index)
          CFG_SCORE_THR:   score_thr_q <= cfg_i.data;
          CFG_OVERLAP_THR: ovl_thr_q   <= cfg_i.data[7:0];
          CFG_MAX_DET:     max_det_q   <= cfg_i.data[6:0];
          default: begin
          end
        endcase
      end

      // anchor position walks the fine grid, then the coarse grid
      if (anchor_acc) begin
        last_q <= is_last;
        if (is_last) begin
          anchor_idx_q <= '0;
          sub_q <= '0;
          cx_q  <= '0;
          cy_q  <= '0;
        end else begin
          anchor_idx_q <= anchor_idx_q + 1'b1;
          if (anchor_idx_q == IDX_W'(FINE_ANCHORS - 1)) begin
            sub_q <= '0;
            cx_q  <= '0;
            cy_q  <= '0;
          end else if (sub_q == (is_fine ? 3'd1 : 3'd5)) begin
            sub_q <= '0;
            if (cx_q == (is_fine ? 4'd15 : 4'd7)) begin
              cx_q <= '0;
              cy_q <= cy_q + 1'b1;
            end else begin
              cx_q <= cx_q + 1'b1;
            end
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
      end

      if (state_q == S_IN) step_q <= '0;
      else if (state_q == S_DIV) step_q <= step_q + 1'b1;

      if (state_q == S_WRITE) cand_cnt_q <= cand_cnt_q + 1'b1;

      if (state_q == S_SCAN_INIT) begin
        scan_i_q    <= '0;
        have_next_q <= 1'b0;
      end else if (scan_adv) begin
        scan_i_q <= scan_i_q + 1'b1;
      end
      if (cons_en && (rd_q.conf > next_q.conf || !have_next_q)) have_next_q <= 1'b1;

      if (mark_en) marks_q[scan_i_q[AW-1:0]] <= 1'b1;

      if (state_q == S_PROMOTE) begin
        have_best_q <= 1'b1;
        emit_cnt_q  <= emit_next;
      end

      if (frame_done) begin
        cand_cnt_q  <= '0;
        emit_cnt_q  <= '0;
        marks_q     <= '0;
        have_best_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (anchor_acc) begin
      neg_q      <= anchor_i.score_logit[15];
      ox_q       <= anchor_i.offset_x;
      oy_q       <= anchor_i.offset_y;
      w_q        <= anchor_i.size_w;
      h_q        <= anchor_i.size_h;
      centre_x_q <= centre_x;
      centre_y_q <= centre_y;
      rem_q      <= {1'b0, abs_logit};
      den_q      <= {1'b0, abs_logit} + 17'd256;
      quo_q      <= '0;
    end else if (state_q == S_DIV) begin
      rem_q <= rem_ge ? 17'(rem2 - {1'b0, den_q}) : rem2[16:0];
      quo_q <= {quo_q[13:0], rem_ge};
    end

    if (state_q == S_SCAN_RD) rd_q <= mem_q[scan_i_q[AW-1:0]];

    if (state_q == S_SCAN_INIT) begin
      next_q.conf <= '0;
      area_best_q <= prod_q[29:0];
    end else if (cons_en && (rd_q.conf > next_q.conf || !have_next_q)) begin
      next_q     <= rd_q;
      next_idx_q <= scan_i_q[AW-1:0];
    end

    if (state_q == S_OV_IW) begin
      iw_q <= 18'(ix2) - 18'(ix1);
      ih_q <= 18'(iy2) - 18'(iy1);
    end
    if (state_q == S_OV_AREA) inter_q <= prod_q[29:0];
    if (state_q == S_OV_UNION) uni_q <= area_best_q + prod_q[29:0] - inter_q;

    if (state_q == S_PROMOTE) begin
      best_q     <= next_q;
      best_idx_q <= next_idx_q;
    end

    // output register loads
    if (state_q == S_ROUND_END) begin
      if (have_best_q) begin
        out_q      <= best_q;
        out_none_q <= 1'b0;
        out_end_q  <= !have_next_q;
      end else begin
        out_q      <= '0;
        out_none_q <= 1'b1;
        out_end_q  <= 1'b1;
      end
    end else if (state_q == S_PROMOTE) begin
      out_q      <= next_q;
      out_none_q <= 1'b0;
      out_end_q  <= 1'b1;
    end
  end

  // candidate store
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) mem_q[cand_cnt_q[AW-1:0]] <= new_cand;
  end

  // ---------------------------------------------------------------- assertions
  a_cand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_cnt_q <= CW'(MAX_CANDIDATES))
    else $error("candidate count beyond store depth");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= EMIT_W'(RESULT_LIMIT))
    else $error("emitted count beyond limit");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (cand_cnt_q < CW'(MAX_CANDIDATES)))
    else $error("store write with store full");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.none_found) |->
      (result_o.frame_end && result_o.confidence == '0 && result_o.box_width == '0))
    else $error("empty frame result carries data");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_acc && result_o.frame_end) |=>
      (cand_cnt_q == '0 && emit_cnt_q == '0 && marks_q == '0 && state_q == S_IN))
    else $error("frame state not cleared after last result");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the face box decoder with hard nms
// depends on fbd_pkg, the channel interfaces in fbd_if.sv and face_box_decode_nms_core
`default_nettype none

module tb;
  import fbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  fbd_cfg_if    cfg_ch ();
  fbd_anchor_if anchor_ch ();
  fbd_result_if result_ch ();

  face_box_decode_nms_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch),
    .anchor_i(anchor_ch),
    .result_o(result_ch)
  );

  typedef struct {
    logic signed [15:0] logit;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } anchor_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [15:0]        conf;
    logic               none_found;
    logic               frame_end;
  } box_result_t;

  // how the anchors of one frame are drawn
  typedef enum {FR_DIRECTED, FR_SPARSE, FR_DENSE, FR_CLUSTER} frame_kind_e;

  // predictor copy of the registers and the per-frame state
  logic signed [15:0] score_thr;
  logic [7:0]         overlap_thr;
  logic [6:0]         max_det;
  int                 anchor_idx;
  int                 cand_count;
  cand_t              cand_mem [MAX_CAND_DEF];
  bit                 cand_gone [MAX_CAND_DEF];

  anchor_t     anchors_to_send [$];
  box_result_t boxes_expected [$];
  int          frames_queued;
  int          frames_decoded;
  int          errors;
  bit          hold_arm;
  bit          hold_used;
  int          hold_cnt;

  // -------------------------------------------------------------------
  // clock and the run limit
  // -------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // -------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------
  // quarter rounding of a doubled edge, then saturation to 16 bits signed
  function automatic logic signed [15:0] edge_pos(longint ofs, longint ctr, longint sz);
    longint e;
    longint r;
    e = 2 * (ofs + ctr) - sz;
    r = (e + 2) >>> 2;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // cheap sigmoid 0.5 + x / (2 (1 + |x|)) with x = l / 256, in q0.16
  function automatic logic [15:0] confidence_of(logic signed [15:0] l);
    longint a;
    longint t;
    a = (l < 0) ? -longint'(l) : longint'(l);
    t = (32768 * a) / (256 + a);
    return (l < 0) ? 16'(32768 - t) : 16'(32768 + t);
  endfunction

  function automatic bit iou_above(cand_t a, cand_t b);
    longint ix1, iy1, ix2, iy2, ax2, ay2, bx2, by2, iw, ih, inter, uni;
    ix1 = (a.left > b.left) ? a.left : b.left;
    iy1 = (a.top > b.top) ? a.top : b.top;
    ax2 = longint'(a.left) + a.width;
    bx2 = longint'(b.left) + b.width;
    ay2 = longint'(a.top) + a.height;
    by2 = longint'(b.top) + b.height;
    ix2 = (ax2 < bx2) ? ax2 : bx2;
    iy2 = (ay2 < by2) ? ay2 : by2;
    iw = ix2 - ix1;
    ih = iy2 - iy1;
    if (iw <= 0 || ih <= 0) return 1'b0;
    inter = iw * ih;
    uni = longint'(a.width) * a.height + longint'(b.width) * b.height - inter;
    if (uni <= 0) return 1'b0;
    return inter * 256 > longint'(overlap_thr) * uni;
  endfunction

  // hard nms over the stored candidates, fills the expected boxes of the frame
  task automatic run_nms();
    int limit;
    int emitted;
    int best;
    int unsigned best_conf;
    box_result_t r;
    limit = (max_det < 1) ? 1 : ((max_det > RESULT_LIMIT) ? RESULT_LIMIT : int'(max_det));
    emitted = 0;
    while (emitted < limit) begin
      best = -1;
      best_conf = 0;
      // strict compare keeps the earlier candidate on equal confidence
      for (int i = 0; i < cand_count; i++) begin
        if (!cand_gone[i] && cand_mem[i].conf > best_conf) begin
          best_conf = cand_mem[i].conf;
          best = i;
        end
      end
      if (best < 0) break;
      r.left       = cand_mem[best].left;
      r.top        = cand_mem[best].top;
      r.width      = cand_mem[best].width;
      r.height     = cand_mem[best].height;
      r.conf       = cand_mem[best].conf;
      r.none_found = 1'b0;
      r.frame_end  = 1'b0;
      boxes_expected.push_back(r);
      emitted++;
      cand_gone[best] = 1'b1;
      for (int i = 0; i < cand_count; i++) begin
        if (!cand_gone[i] && iou_above(cand_mem[best], cand_mem[i])) cand_gone[i] = 1'b1;
      end
    end
    if (emitted == 0) begin
      // empty frame gives a single flagged item with all fields zero
      r = '{default: '0};
      r.none_found = 1'b1;
      boxes_expected.push_back(r);
    end
    boxes_expected[$].frame_end = 1'b1;
  endtask

  task automatic decode_anchor(input anchor_t a);
    longint cx;
    longint cy;
    int grid_pos;
    if (a.logit > score_thr && a.w > 0 && a.h > 0 && cand_count < MAX_CAND_DEF) begin
      if (anchor_idx < FINE_ANCHORS) begin
        grid_pos = anchor_idx >> 1;
        cx = (2 * (grid_pos % 16) + 1) * 1024;
        cy = (2 * ((grid_pos / 16) % 16) + 1) * 1024;
      end else begin
        grid_pos = (anchor_idx - FINE_ANCHORS) / 6;
        cx = (2 * (grid_pos % 8) + 1) * 2048;
        cy = (2 * ((grid_pos / 8) % 8) + 1) * 2048;
      end
      cand_mem[cand_count].left   = edge_pos(a.ox, cx, a.w);
      cand_mem[cand_count].top    = edge_pos(a.oy, cy, a.h);
      cand_mem[cand_count].width  = 15'((int'(a.w) + 1) >> 1);
      cand_mem[cand_count].height = 15'((int'(a.h) + 1) >> 1);
      cand_mem[cand_count].conf   = confidence_of(a.logit);
      cand_count++;
    end
    if (anchor_idx + 1 < TOTAL_ANCHORS) begin
      anchor_idx++;
    end else begin
      run_nms();
      anchor_idx = 0;
      cand_count = 0;
      foreach (cand_gone[i]) cand_gone[i] = 1'b0;
      frames_decoded++;
    end
  endtask

  // -------------------------------------------------------------------
  // idling schedule: sender 7 / receiver 66 first, then swapped, then none
  // -------------------------------------------------------------------
  function automatic int sender_idle_pct();
    if (frames_decoded < 3) return 7;
    if (frames_decoded < 5) return 66;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (frames_decoded < 3) return 66;
    if (frames_decoded < 5) return 7;
    return 0;
  endfunction

  // -------------------------------------------------------------------
  // anchor driver: predicts on every accepted item
  // -------------------------------------------------------------------
  always @(posedge clk_i) begin
    anchor_t a;
    if (rst_ni) begin
      if (anchor_ch.valid && anchor_ch.ready) begin
        a.logit = anchor_ch.score_logit;
        a.ox    = anchor_ch.offset_x;
        a.oy    = anchor_ch.offset_y;
        a.w     = anchor_ch.size_w;
        a.h     = anchor_ch.size_h;
        decode_anchor(a);
      end
      if (!anchor_ch.valid || anchor_ch.ready) begin
        if (anchors_to_send.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          a = anchors_to_send.pop_front();
          anchor_ch.valid       <= 1'b1;
          anchor_ch.score_logit <= a.logit;
          anchor_ch.offset_x    <= a.ox;
          anchor_ch.offset_y    <= a.oy;
          anchor_ch.size_w      <= a.w;
          anchor_ch.size_h      <= a.h;
        end else begin
          anchor_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the output, armed once, counted here
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm && !hold_used && result_ch.valid) begin
      hold_cnt  <= 3000;
      hold_used <= 1'b1;
    end
  end

  // result receiver and checker
  always @(posedge clk_i) begin
    box_result_t got;
    box_result_t want;
    if (rst_ni) begin
      result_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= receiver_idle_pct());
      if (result_ch.valid && result_ch.ready) begin
        got.left       = result_ch.box_left;
        got.top        = result_ch.box_top;
        got.width      = result_ch.box_width;
        got.height     = result_ch.box_height;
        got.conf       = result_ch.confidence;
        got.none_found = result_ch.none_found;
        got.frame_end  = result_ch.frame_end;
        if (boxes_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected item %p", got));
        end else begin
          want = boxes_expected.pop_front();
          if (got !== want) note_mismatch($sformatf("got %p want %p", got, want));
        end
      end
    end
  end

  // -------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------
  function automatic logic signed [15:0] rand16();
    return 16'($urandom);
  endfunction

  // logits far below every threshold used except the most negative one
  function automatic logic signed [15:0] low_logit();
    return 16'(-32768 + $urandom_range(1, 19000));
  endfunction

  function automatic anchor_t random_anchor(frame_kind_e kind);
    anchor_t a;
    int pick;
    pick = $urandom_range(0, 99);
    case (kind)
      FR_SPARSE:  a.logit = (pick < 10) ? rand16() : low_logit();
      FR_DENSE:   a.logit = rand16();
      default: begin
        // a small set of logits gives ties in confidence
        if (pick < 15) a.logit = 16'(100 * $urandom_range(1, 4));
        else if (pick < 35) a.logit = rand16();
        else a.logit = low_logit();
      end
    endcase
    if (kind == FR_CLUSTER) begin
      a.ox = 16'(int'($urandom_range(0, 511)) - 256);
      a.oy = 16'(int'($urandom_range(0, 511)) - 256);
      a.w  = 16'($urandom_range(2000, 6000));
      a.h  = 16'($urandom_range(2000, 6000));
    end else begin
      pick = $urandom_range(0, 99);
      a.ox = (pick < 80) ? 16'(int'($urandom_range(0, 4095)) - 2048) : rand16();
      a.oy = (pick < 80) ? 16'(int'($urandom_range(0, 4095)) - 2048) : rand16();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        a.w = 16'($urandom_range(1, 12000));
        a.h = 16'($urandom_range(1, 12000));
      end else if (pick < 95) begin
        a.w = rand16();
        a.h = rand16();
      end else begin
        a.w = 16'sd0;
        a.h = 16'($urandom_range(1, 12000));
      end
    end
    return a;
  endfunction

  task automatic queue_frame(frame_kind_e kind);
    anchor_t fixed [$];
    anchor_t a;
    if (kind == FR_DIRECTED) begin
      // extremes: offset low and high, smallest box, threshold edge, bad sizes
      fixed.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
      fixed.push_back('{16'sd105, 16'sh7fff, 16'sh7fff, 16'sd1, 16'sd1});
      fixed.push_back('{16'sd104, 16'sd0, 16'sd0, 16'sd100, 16'sd100});
      fixed.push_back('{16'sd200, 16'sd0, 16'sd0, 16'sd0, 16'sd100});
      fixed.push_back('{16'sd200, 16'sd0, 16'sd0, 16'sd100, -16'sd5});
      fixed.push_back('{16'sh8000, 16'sd0, 16'sd0, 16'sd100, 16'sd100});
      fixed.push_back('{16'sd300, 16'sd0, 16'sd0, 16'sh8000, 16'sd100});
      fixed.push_back('{-16'sd1, 16'sd0, 16'sd0, 16'sd100, 16'sd100});
      // two anchors of one cell with equal score and the same box
      fixed.push_back('{16'sd500, 16'sd0, 16'sd0, 16'sd3000, 16'sd3000});
      fixed.push_back('{16'sd500, 16'sd0, 16'sd0, 16'sd3000, 16'sd3000});
      fixed.push_back('{16'sd500, 16'sd12000, 16'sd0, 16'sd3000, 16'sd3000});
      fixed.push_back('{16'sd1000, 16'sd600, 16'sd400, 16'sd3000, 16'sd3000});
      fixed.push_back('{16'sd2000, -16'sd700, 16'sd0, 16'sd2999, 16'sd3001});
    end
    for (int i = 0; i < TOTAL_ANCHORS; i++) begin
      if (i < fixed.size()) begin
        a = fixed[i];
      end else if (kind == FR_DIRECTED) begin
        a = random_anchor(FR_SPARSE);
        if (i != 520 && i != TOTAL_ANCHORS - 1) a.logit = low_logit();
        else a.logit = 16'sd4000;
        if (i == 520 || i == TOTAL_ANCHORS - 1) begin
          a.w = 16'sd5000;
          a.h = 16'sd5000;
        end
      end else begin
        a = random_anchor(kind);
      end
      anchors_to_send.push_back(a);
    end
    frames_queued++;
  endtask

  task automatic wait_idle();
    while (anchors_to_send.size() > 0 || frames_decoded != frames_queued
           || boxes_expected.size() > 0)
      @(posedge clk_i);
    // a quiet gap after the last item
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SCORE_THR:   score_thr   = val;
      CFG_OVERLAP_THR: overlap_thr = val[7:0];
      CFG_MAX_DET:     max_det     = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] thr, logic [7:0] ovl, logic [6:0] det);
    write_reg(CFG_SCORE_THR, thr);
    write_reg(CFG_OVERLAP_THR, 16'(ovl));
    write_reg(CFG_MAX_DET, 16'(det));
  endtask

  initial begin
    rst_ni                = 1'b0;
    anchor_ch.valid       = 1'b0;
    anchor_ch.score_logit = '0;
    anchor_ch.offset_x    = '0;
    anchor_ch.offset_y    = '0;
    anchor_ch.size_w      = '0;
    anchor_ch.size_h      = '0;
    result_ch.ready       = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    score_thr             = SCORE_THR_RST;
    overlap_thr           = OVL_THR_RST;
    max_det               = MAX_DET_RST;
    anchor_idx            = 0;
    cand_count            = 0;
    foreach (cand_gone[i]) cand_gone[i] = 1'b0;
    frames_queued         = 0;
    frames_decoded        = 0;
    errors                = 0;
    hold_arm              = 1'b0;
    hold_used             = 1'b0;
    hold_cnt              = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, directed frame then a random one
    queue_frame(FR_DIRECTED);
    queue_frame(FR_SPARSE);
    wait_idle();

    // everything but the lowest logit passes, store overflows, limit above 64
    set_regs(16'sh8000, 8'd255, 7'd127);
    queue_frame(FR_DENSE);
    wait_idle();

    // nothing passes, limit zero acts as one
    set_regs(16'sh7fff, 8'd0, 7'd0);
    queue_frame(FR_DENSE);
    wait_idle();

    // two frames back to back while the output is held off
    set_regs(16'sd0, 8'd77, 7'd1);
    hold_arm = 1'b1;
    queue_frame(FR_CLUSTER);
    queue_frame(FR_DENSE);
    wait_idle();

    set_regs(-16'sd200, 8'd200, 7'd64);
    queue_frame(FR_CLUSTER);
    wait_idle();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
